>>> rtl/rrsa_pkg.sv
// Package for the round-robin switch allocator.
// Holds the sizes, item-kind codes and word and struct types that all files share.
// Depends on nothing.
`default_nettype none

package rrsa_pkg;

   localparam int NUM_PORTS = 5;
   localparam int NUM_VCS   = 4;
   localparam int TOTAL_REQ = NUM_PORTS * NUM_VCS;

   // Field widths are fixed by the word format.
   localparam int PORT_W = 3;
   localparam int VC_W   = 2;
   localparam int KIND_W = 2;
   localparam int IDX_W  = $clog2(TOTAL_REQ);

   localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PICK  = 2'd2;

   typedef logic [NUM_PORTS-1:0][NUM_VCS-1:0] rrsa_row_type;

   typedef struct packed {
      logic [KIND_W-1:0] req_type;
      logic [PORT_W-1:0] out_port;
      logic [PORT_W-1:0] in_port;
      logic [VC_W-1:0]   in_vc;
   } rrsa_req_word_type;

   typedef struct packed {
      logic              granted;
      logic [PORT_W-1:0] win_port;
      logic [VC_W-1:0]   win_vc;
   } rrsa_rsp_word_type;

   // State update from the top level to the request table.
   typedef struct packed {
      logic              bit_en;
      logic              bit_val;
      logic              ptr_en;
      logic [PORT_W-1:0] row;
      logic [PORT_W-1:0] in_port;
      logic [VC_W-1:0]   in_vc;
      logic [IDX_W-1:0]  ptr_idx;
   } rrsa_upd_type;

   // Outcome of one round-robin scan.
   typedef struct packed {
      logic              found;
      logic [PORT_W-1:0] win_port;
      logic [VC_W-1:0]   win_vc;
      logic [IDX_W-1:0]  win_idx;
   } rrsa_pick_type;

endpackage

`default_nettype wire

>>> rtl/rrsa_req_if.sv
// Valid/ready channel that carries request words into the allocator.
// Depends on rrsa_pkg for the word type.
`default_nettype none

interface rrsa_req_if
   import rrsa_pkg::*;
();
   logic              valid;
   logic              ready;
   rrsa_req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/rrsa_rsp_if.sv
// Valid/ready channel that carries grant words out of the allocator.
// Depends on rrsa_pkg for the word type.
`default_nettype none

interface rrsa_rsp_if
   import rrsa_pkg::*;
();
   logic              valid;
   logic              ready;
   rrsa_rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/round_robin_switch_allocator.sv
// Top level of the round-robin switch allocator.
// Depends on rrsa_pkg, rrsa_req_if, rrsa_rsp_if, rrsa_req_table and rrsa_rr_pick.
`default_nettype none

//  Channel   Direction  Word                                   Handshake
//  req_chan  in         req_type, out_port, in_port, in_vc      valid/ready
//  rsp_chan  out        granted, win_port, win_vc               valid/ready
//
// An accepted word is held in the input register. A set or clear updates the table,
// and a pick's 20-way rotating scan loads the result register once it has room. A grant
// is then offered from the result register, and a word can enter every cycle unless a pick waits.
// Synchronous reset clears all request bits, points every arbiter just before
// requester 0 and empties both registers. Only a pick waits for room in the result
// register. While it waits the input stalls; set and clear words otherwise pass freely.

module round_robin_switch_allocator
   import rrsa_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   rrsa_req_if.sink   req_chan,
   rrsa_rsp_if.source rsp_chan
);

   // Input register.
   logic              in_valid_ff;
   logic              in_valid_in;
   rrsa_req_word_type in_word_ff;

   // Result register.
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rrsa_rsp_word_type rsp_word_ff;
   rrsa_rsp_word_type rsp_word_in;

   rrsa_row_type     row;
   logic [IDX_W-1:0] last;
   rrsa_pick_type    pick;
   rrsa_upd_type     upd;

   logic port_ok;
   logic src_ok;
   logic is_setclr;
   logic is_pick;
   logic out_free;
   logic advance;
   logic in_ready;

   // Decode of the held word. Words with out-of-range indices or an unknown
   // kind pass through without effect.
   assign port_ok   = 32'(in_word_ff.out_port) < NUM_PORTS;
   assign src_ok    = (32'(in_word_ff.in_port) < NUM_PORTS) &&
                      (32'(in_word_ff.in_vc) < NUM_VCS);
   assign is_setclr = port_ok && src_ok &&
                      ((in_word_ff.req_type == KIND_SET) || (in_word_ff.req_type == KIND_CLEAR));
   assign is_pick   = port_ok && (in_word_ff.req_type == KIND_PICK);

   // Only a pick needs room in the result register.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign advance  = in_valid_ff && (!is_pick || out_free);
   assign in_ready = !in_valid_ff || advance;

   rrsa_req_table u_table (
      .clock   (clock),
      .reset   (reset),
      .upd     (upd),
      .rd_port (in_word_ff.out_port),
      .rd_row  (row),
      .rd_last (last)
   );

   rrsa_rr_pick u_pick (
      .row  (row),
      .last (last),
      .pick (pick)
   );

   always_comb begin
      upd.bit_en  = advance && is_setclr;
      upd.bit_val = (in_word_ff.req_type == KIND_SET);
      upd.ptr_en  = advance && is_pick && pick.found;
      upd.row     = in_word_ff.out_port;
      upd.in_port = in_word_ff.in_port;
      upd.in_vc   = in_word_ff.in_vc;
      upd.ptr_idx = pick.win_idx;
   end

   // A grant does not clear its request; an empty row returns all zeros.
   always_comb begin
      rsp_word_in.granted  = pick.found;
      rsp_word_in.win_port = pick.found ? pick.win_port : '0;
      rsp_word_in.win_vc   = pick.found ? pick.win_vc : '0;
   end

   always_comb begin
      if (in_ready) begin
         in_valid_in = req_chan.valid;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance && is_pick) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         in_word_ff <= req_chan.data;
      end
      if (advance && is_pick) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign req_chan.ready = in_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_word_ff;

endmodule

`default_nettype wire

>>> rtl/rrsa_req_table.sv
// Request bit table and last-winner pointers, one row per output port.
// Depends on rrsa_pkg.
`default_nettype none

module rrsa_req_table
   import rrsa_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire rrsa_upd_type      upd,
   input  wire logic [PORT_W-1:0] rd_port,
   output rrsa_row_type           rd_row,
   output logic [IDX_W-1:0]       rd_last
);

   rrsa_row_type     rows_ff [NUM_PORTS];
   logic [IDX_W-1:0] last_ff [NUM_PORTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < NUM_PORTS; p++) begin
            rows_ff[p] <= '0;
            last_ff[p] <= IDX_W'(TOTAL_REQ - 1);
         end
      end else begin
         if (upd.bit_en) begin
            rows_ff[upd.row][upd.in_port][upd.in_vc] <= upd.bit_val;
         end
         if (upd.ptr_en) begin
            last_ff[upd.row] <= upd.ptr_idx;
         end
      end
   end

   assign rd_row  = rows_ff[rd_port];
   assign rd_last = last_ff[rd_port];

endmodule

`default_nettype wire

>>> rtl/rrsa_rr_pick.sv
// Rotating priority encoder: finds the first requester after the last winner.
// Depends on rrsa_pkg.
`default_nettype none

module rrsa_rr_pick
   import rrsa_pkg::*;
(
   input  wire rrsa_row_type     row,
   input  wire logic [IDX_W-1:0] last,
   output rrsa_pick_type         pick
);

   rrsa_pick_type hi_pick;
   rrsa_pick_type any_pick;

   // Two plain priority encodes: one over requesters above the pointer,
   // one over the whole row for the wrap-around case.
   always_comb begin
      hi_pick  = '0;
      any_pick = '0;
      for (int p = NUM_PORTS - 1; p >= 0; p--) begin
         for (int v = NUM_VCS - 1; v >= 0; v--) begin
            if (row[p][v]) begin
               any_pick.found    = 1'b1;
               any_pick.win_port = PORT_W'(p);
               any_pick.win_vc   = VC_W'(v);
               any_pick.win_idx  = IDX_W'(p * NUM_VCS + v);
               if (IDX_W'(p * NUM_VCS + v) > last) begin
                  hi_pick.found    = 1'b1;
                  hi_pick.win_port = PORT_W'(p);
                  hi_pick.win_vc   = VC_W'(v);
                  hi_pick.win_idx  = IDX_W'(p * NUM_VCS + v);
               end
            end
         end
      end
      pick = hi_pick.found ? hi_pick : any_pick;
   end

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for the round-robin switch allocator.
// Holds a small grant scoreboard class and the driving tasks of the top module tb.
// Depends on rrsa_pkg, rrsa_req_if, rrsa_rsp_if and round_robin_switch_allocator.
`default_nettype none

module tb;
   import rrsa_pkg::*;

   // Request kind that the block does not know.
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

   // The scoreboard keeps its own copy of the request rows and last-winner
   // pointers, predicts the grant word of every accepted pick and checks the
   // grant words that leave the block in order.
   class grant_scoreboard;
      bit [TOTAL_REQ-1:0] req_row [NUM_PORTS];
      int unsigned        last_idx [NUM_PORTS];
      rrsa_rsp_word_type  grants_due [$];
      int errors, n_set, n_clear, n_pick, n_granted, n_empty, n_ignored, n_checked;

      function new();
         for (int p = 0; p < NUM_PORTS; p++) begin
            req_row[p]  = '0;
            last_idx[p] = TOTAL_REQ - 1;
         end
         errors    = 0;
         n_set     = 0;
         n_clear   = 0;
         n_pick    = 0;
         n_granted = 0;
         n_empty   = 0;
         n_ignored = 0;
         n_checked = 0;
      endfunction

      task report_mismatch(input string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      // Applies one accepted request word to the model state.
      function void note_word(input rrsa_req_word_type w);
         int unsigned       start;
         int unsigned       idx;
         bit                hit;
         rrsa_rsp_word_type g;
         if (w.out_port >= NUM_PORTS) begin
            n_ignored++;
            return;
         end
         case (w.req_type)
            KIND_SET, KIND_CLEAR: begin
               if (w.in_port >= NUM_PORTS || w.in_vc >= NUM_VCS) begin
                  n_ignored++;
               end else begin
                  req_row[w.out_port][w.in_port * NUM_VCS + w.in_vc] =
                     (w.req_type == KIND_SET);
                  if (w.req_type == KIND_SET) n_set++;
                  else n_clear++;
               end
            end
            KIND_PICK: begin
               n_pick++;
               g     = '0;
               hit   = 1'b0;
               start = (last_idx[w.out_port] + 1) % TOTAL_REQ;
               for (int i = 0; i < TOTAL_REQ && !hit; i++) begin
                  idx = (start + i) % TOTAL_REQ;
                  if (req_row[w.out_port][idx]) begin
                     hit                  = 1'b1;
                     last_idx[w.out_port] = idx;
                     g.granted            = 1'b1;
                     g.win_port           = PORT_W'(idx / NUM_VCS);
                     g.win_vc             = VC_W'(idx % NUM_VCS);
                  end
               end
               if (hit) n_granted++;
               else n_empty++;
               grants_due = {grants_due, g};
            end
            default: n_ignored++;
         endcase
      endfunction

      // Compares one accepted grant word with the oldest prediction.
      task check_grant(input rrsa_rsp_word_type got);
         rrsa_rsp_word_type exp;
         if (grants_due.size() == 0) begin
            report_mismatch($sformatf("grant word %b with no pick outstanding", got));
            return;
         end
         exp = grants_due[0];
         grants_due.delete(0);
         n_checked++;
         if (got.granted !== exp.granted)
            report_mismatch($sformatf("granted %b, expected %b", got.granted, exp.granted));
         if (got.win_port !== exp.win_port)
            report_mismatch($sformatf("win_port %0d, expected %0d", got.win_port, exp.win_port));
         if (got.win_vc !== exp.win_vc)
            report_mismatch($sformatf("win_vc %0d, expected %0d", got.win_vc, exp.win_vc));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   rrsa_req_if req_bus ();
   rrsa_rsp_if rsp_bus ();

   round_robin_switch_allocator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   grant_scoreboard sb = new();

   // Idle percentages of the current phase, and the long hold-off request that
   // the grant receiver picks up and counts out in its own process.
   int unsigned tx_idle_pct = 0;
   int unsigned rx_stall_pct = 0;
   bit          hold_req = 1'b0;
   int unsigned hold_left = 0;

   always #2 clock = ~clock;

   // Both channels are watched at the rising edge. Since every input is driven
   // with a nonblocking assignment at the edge and the block updates its
   // outputs the same way, the values read here are the ones that the block
   // itself saw at this edge, so a handshake is seen exactly when it happens.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) sb.note_word(req_bus.data);
         if (rsp_bus.valid && rsp_bus.ready) sb.check_grant(rsp_bus.data);
      end
   end

   // Grant receiver. A pending hold-off request turns into a long run of
   // cycles with ready low; otherwise ready follows the phase's stall rate.
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Offers one word and returns at the edge where it is taken. Valid stays
   // high into the next word unless the sender decides to idle, so it is never
   // lowered and raised within one time step. During an idle stretch the
   // payload carries junk so that nothing relies on stale data.
   task automatic send_word(input rrsa_req_word_type w);
      req_bus.valid <= 1'b1;
      req_bus.data  <= w;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         req_bus.data  <= rrsa_req_word_type'($urandom);
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
   endtask

   task automatic send_fields(input logic [KIND_W-1:0] kind, input int unsigned op,
                              input int unsigned ip, input int unsigned vc);
      rrsa_req_word_type w;
      w.req_type = kind;
      w.out_port = PORT_W'(op);
      w.in_port  = PORT_W'(ip);
      w.in_vc    = VC_W'(vc);
      send_word(w);
   endtask

   initial begin
      rrsa_req_word_type w;
      int unsigned       r;
      int unsigned       op;
      int unsigned       counted;
      int unsigned       drain_wait;

      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.data  = '0;
      rsp_bus.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Requests at the far corners of the table: requester 0
      // of port 0 and the last VC of the last input port on the last output.
      send_fields(KIND_SET, 0, 0, 0);
      send_fields(KIND_SET, 4, 4, 3);
      send_fields(KIND_PICK, 0, 7, 3);     // pick ignores in_port and in_vc
      send_fields(KIND_PICK, 0, 0, 0);     // lone requester wins again
      send_fields(KIND_PICK, 4, 0, 0);     // scan from 0 wraps to the last index
      send_fields(KIND_PICK, 2, 0, 0);     // empty row, no grant
      send_fields(KIND_CLEAR, 0, 0, 0);
      send_fields(KIND_PICK, 0, 0, 0);     // row emptied by the clear
      // Two requesters on one port must alternate, starting with the lower one.
      send_fields(KIND_SET, 1, 1, 2);
      send_fields(KIND_SET, 1, 3, 0);
      send_fields(KIND_PICK, 1, 0, 0);
      send_fields(KIND_PICK, 1, 0, 0);
      send_fields(KIND_PICK, 1, 0, 0);
      // Words the block must drop: unknown kind, output port out of range on
      // pick and set, and an input port out of range on set and clear.
      send_fields(KIND_UNKNOWN, 3, 2, 1);
      send_fields(KIND_PICK, 5, 0, 0);
      send_fields(KIND_PICK, 7, 0, 0);
      send_fields(KIND_SET, 6, 1, 1);
      send_fields(KIND_SET, 3, 5, 0);
      send_fields(KIND_SET, 3, 7, 3);
      send_fields(KIND_CLEAR, 1, 6, 2);
      send_fields(KIND_PICK, 3, 0, 0);     // still empty after the dropped sets
      send_fields(KIND_PICK, 1, 0, 0);     // clear with bad port left row 1 intact

      // Random part in four idle modes. Most words are well-formed sets,
      // clears and picks; a few are noise, and now and then a whole row is
      // drained so that empty-row picks keep happening after the table fills.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 45; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 45; end
            default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
         endcase
         // In the first phase the receiver holds off for a long stretch while
         // words keep coming, so picks back up and the input stalls.
         if (phase == 0) hold_req = 1'b1;
         counted = 0;
         while (counted < 475) begin
            r = $urandom_range(99);
            if (r < 1) begin
               op = $urandom_range(NUM_PORTS - 1);
               for (int ip = 0; ip < NUM_PORTS; ip++)
                  for (int vc = 0; vc < NUM_VCS; vc++)
                     send_fields(KIND_CLEAR, op, ip, vc);
               send_fields(KIND_PICK, op, $urandom, $urandom);
               counted += TOTAL_REQ + 1;
            end else begin
               if (r < 7) begin
                  w = rrsa_req_word_type'($urandom);
               end else begin
                  w.out_port = PORT_W'($urandom_range(NUM_PORTS - 1));
                  if (r < 45) begin
                     w.req_type = KIND_SET;
                  end else if (r < 63) begin
                     w.req_type = KIND_CLEAR;
                  end else begin
                     w.req_type = KIND_PICK;
                  end
                  if (w.req_type == KIND_PICK) begin
                     w.in_port = PORT_W'($urandom);
                     w.in_vc   = VC_W'($urandom);
                  end else begin
                     w.in_port = PORT_W'($urandom_range(NUM_PORTS - 1));
                     w.in_vc   = VC_W'($urandom_range(NUM_VCS - 1));
                  end
               end
               send_word(w);
               // Only words that reach the table or the arbiter count.
               if (w.out_port < NUM_PORTS &&
                   (w.req_type == KIND_PICK ||
                    ((w.req_type == KIND_SET || w.req_type == KIND_CLEAR) &&
                     w.in_port < NUM_PORTS)))
                  counted++;
            end
         end
      end

      // Stop offering words, then let every predicted grant drain out. The
      // first edge makes sure the last accepted word has been noted.
      req_bus.valid <= 1'b0;
      @(posedge clock);
      drain_wait = 0;
      while (sb.grants_due.size() > 0 && drain_wait < 20000) begin
         @(posedge clock);
         drain_wait++;
      end
      repeat (4) @(posedge clock);
      if (sb.grants_due.size() > 0)
         sb.report_mismatch($sformatf("%0d grant words never arrived", sb.grants_due.size()));

      $display("Covered %0d set, %0d clear and %0d pick words (%0d granted, %0d empty),",
               sb.n_set, sb.n_clear, sb.n_pick, sb.n_granted, sb.n_empty);
      $display("%0d dropped; idling, gaps, stalls and one long hold-off; %0d grants checked.",
               sb.n_ignored, sb.n_checked);
      if (sb.errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of this stimulus.
   initial begin
      #2000000;
      $display("Watchdog expired before the run completed.");
      $display("tb NOT OK");
      $finish;
   end

endmodule

`default_nettype wire
